// ===== hdl/gws_pkg.sv =====
// Shared types, constants and the word compare for the grid word search counter.
// No dependencies; gws_line_buf, gws_match and the top level refer to this package by scoped names.
package gws_pkg;

    localparam int CHAR_W        = 8;
    localparam int MATCH_W       = 3;
    localparam int TOTAL_W       = 24;
    localparam int ROW_W_W       = 9;
    localparam int WORD_LEN      = 4;
    localparam int ROW_SLOTS     = 3;
    localparam int MAX_COLS_DEF  = 256;

    localparam int S_TDATA_W     = 8;
    localparam int S_TUSER_W     = 1;
    localparam int M_TDATA_W     = 32;
    localparam int M_PAD_W       = M_TDATA_W - MATCH_W - TOTAL_W;

    localparam int APB_DATA_W    = 32;
    localparam int APB_ADDR_W    = 3;

    // register index, taken from paddr above the byte offset
    localparam logic [0:0] REG_ROW_WIDTH = 1'b0;

    localparam logic [ROW_W_W-1:0] ROW_WIDTH_RST = 9'd140;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = {TOTAL_W{1'b1}};

    localparam logic [CHAR_W-1:0] WORD [WORD_LEN] = '{8'h58, 8'h4D, 8'h41, 8'h53};

    // Characters of the rows above, as seen at the current column.
    typedef struct packed {
        logic [CHAR_W-1:0] up1_here;   // one row up, same column
        logic [CHAR_W-1:0] up1_ahead;  // one row up, one column right
        logic [CHAR_W-1:0] up2_here;
        logic [CHAR_W-1:0] up2_ahead;  // two rows up, two columns right
        logic [CHAR_W-1:0] up3_here;   // three rows up; also the displaced entry
        logic [CHAR_W-1:0] up3_ahead;  // three rows up, three columns right
    } taps_t;

    // Per-item control carried along with the line buffer read.
    typedef struct packed {
        logic [CHAR_W-1:0] cur;
        logic              first;
        logic              col_ge3;
        logic              full_rows;
        logic              ahead_ok;
    } item_t;

    // True when the four characters spell the word forward or backward.
    function automatic logic word_hit(input logic [CHAR_W-1:0] a,
                                      input logic [CHAR_W-1:0] b,
                                      input logic [CHAR_W-1:0] c,
                                      input logic [CHAR_W-1:0] d);
        logic [CHAR_W-1:0] w [WORD_LEN];
        logic              fwd;
        logic              rev;
        w[0] = a;
        w[1] = b;
        w[2] = c;
        w[3] = d;
        fwd  = 1'b1;
        rev  = 1'b1;
        for (int k = 0; k < WORD_LEN; k++) begin
            if (w[k] != WORD[k]) begin
                fwd = 1'b0;
            end
            if (w[k] != WORD[WORD_LEN-1-k]) begin
                rev = 1'b0;
            end
        end
        return fwd || rev;
    endfunction

endpackage

// ===== hdl/gws_ram.sv =====
// Generic synchronous RAM: one write port, two read ports, registered read data.
// Read-first on an address that is written in the same cycle. No dependencies.
module gws_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_a,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (re) begin
            rdata_a <= mem_reg[raddr_a];
            rdata_b <= mem_reg[raddr_b];
        end
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
    end

endmodule

// ===== hdl/gws_line_buf.sv =====
// Three rotating row buffers, one RAM per row slot, and the mapping of slots to rows up.
// Depends on gws_pkg and gws_ram.
module gws_line_buf #(
    parameter int MAX_COLS = gws_pkg::MAX_COLS_DEF
) (
    input  logic                        aclk,
    input  logic                        rd_en,
    input  logic [1:0]                  phase,
    input  logic [$clog2(MAX_COLS)-1:0] col,
    input  logic [gws_pkg::CHAR_W-1:0]  cur,
    output gws_pkg::taps_t              taps
);

    localparam int COL_W = $clog2(MAX_COLS);

    logic [gws_pkg::CHAR_W-1:0] rd_here  [gws_pkg::ROW_SLOTS];
    logic [gws_pkg::CHAR_W-1:0] rd_ahead [gws_pkg::ROW_SLOTS];
    logic [1:0]                 phase_reg;

    for (genvar s = 0; s < gws_pkg::ROW_SLOTS; s++) begin : g_slot
        logic [1:0]       slot_dist;
        logic [COL_W-1:0] addr_b;

        // slot at distance d from the current one holds the row 3-d up;
        // the anti-diagonal needs that row 3-d columns to the right
        assign slot_dist = (2'(s) >= phase) ? (2'(s) - phase) : (2'(s) + 2'd3 - phase);
        assign addr_b    = col + COL_W'(2'd3 - slot_dist);

        gws_ram #(
            .WIDTH (gws_pkg::CHAR_W),
            .DEPTH (MAX_COLS)
        ) u_ram (
            .aclk    (aclk),
            .we      (rd_en && (phase == 2'(s))),
            .waddr   (col),
            .wdata   (cur),
            .re      (rd_en),
            .raddr_a (col),
            .raddr_b (addr_b),
            .rdata_a (rd_here[s]),
            .rdata_b (rd_ahead[s])
        );
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            phase_reg <= phase;
        end
    end

    always_comb begin
        case (phase_reg)
            2'd1: begin
                taps.up3_here  = rd_here[1];
                taps.up3_ahead = rd_ahead[1];
                taps.up2_here  = rd_here[2];
                taps.up2_ahead = rd_ahead[2];
                taps.up1_here  = rd_here[0];
                taps.up1_ahead = rd_ahead[0];
            end
            2'd2: begin
                taps.up3_here  = rd_here[2];
                taps.up3_ahead = rd_ahead[2];
                taps.up2_here  = rd_here[0];
                taps.up2_ahead = rd_ahead[0];
                taps.up1_here  = rd_here[1];
                taps.up1_ahead = rd_ahead[1];
            end
            default: begin
                taps.up3_here  = rd_here[0];
                taps.up3_ahead = rd_ahead[0];
                taps.up2_here  = rd_here[1];
                taps.up2_ahead = rd_ahead[1];
                taps.up1_here  = rd_here[2];
                taps.up1_ahead = rd_ahead[2];
            end
        endcase
    end

endmodule

// ===== hdl/gws_match.sv =====
// Window compare for one cell: horizontal, vertical, diagonal and anti-diagonal.
// Keeps the short column history of reads and characters. Depends on gws_pkg.
module gws_match (
    input  logic                        aclk,
    input  logic                        shift,
    input  gws_pkg::item_t              item,
    input  gws_pkg::taps_t              taps,
    output logic [gws_pkg::MATCH_W-1:0] hit_count
);

    logic [gws_pkg::CHAR_W-1:0] cur_h1_reg, cur_h2_reg, cur_h3_reg;
    logic [gws_pkg::CHAR_W-1:0] up1_h1_reg;
    logic [gws_pkg::CHAR_W-1:0] up2_h1_reg, up2_h2_reg;
    logic [gws_pkg::CHAR_W-1:0] up3_h1_reg, up3_h2_reg, up3_h3_reg;
    logic                       hit_horiz, hit_vert, hit_diag, hit_anti;

    // advance the history once per item, as it leaves this stage
    always_ff @(posedge aclk) begin
        if (shift) begin
            cur_h1_reg <= item.cur;
            cur_h2_reg <= cur_h1_reg;
            cur_h3_reg <= cur_h2_reg;
            up1_h1_reg <= taps.up1_here;
            up2_h1_reg <= taps.up2_here;
            up2_h2_reg <= up2_h1_reg;
            up3_h1_reg <= taps.up3_here;
            up3_h2_reg <= up3_h1_reg;
            up3_h3_reg <= up3_h2_reg;
        end
    end

    always_comb begin
        hit_horiz = item.col_ge3 &&
                    gws_pkg::word_hit(cur_h3_reg, cur_h2_reg, cur_h1_reg, item.cur);
        hit_vert  = item.full_rows &&
                    gws_pkg::word_hit(taps.up3_here, taps.up2_here, taps.up1_here, item.cur);
        hit_diag  = item.full_rows && item.col_ge3 &&
                    gws_pkg::word_hit(up3_h3_reg, up2_h2_reg, up1_h1_reg, item.cur);
        hit_anti  = item.full_rows && item.ahead_ok &&
                    gws_pkg::word_hit(taps.up3_ahead, taps.up2_ahead, taps.up1_ahead,
                                      item.cur);
        hit_count = gws_pkg::MATCH_W'(hit_horiz) + gws_pkg::MATCH_W'(hit_vert) +
                    gws_pkg::MATCH_W'(hit_diag) + gws_pkg::MATCH_W'(hit_anti);
    end

endmodule

// ===== hdl/grid_word_search_counter.sv =====
// Top level of the grid word search counter: stream ports, APB register, position
// counters, result register. Depends on gws_pkg, gws_line_buf and gws_match.
//
// Characters of a letter grid enter in raster order, one per clock when the result side
// keeps up, and each produces one result holding the words (XMAS or SAMX, in any of the
// four line directions) that end at that cell plus a saturating running total. The rate
// is set by the three row-slot RAMs: each item writes one entry and reads two columns of
// every slot in its accept cycle, and the compare and total update sit in the following
// stage. tuser high restarts position and total on that character; the row buffers keep
// their contents and need no clearing pass after reset. row_width (1 to MAX_COLS, 0 acts
// as 1) lies at address 0; the user writes it only while idle, which is not enforced.
module grid_word_search_counter #(
    parameter int MAX_COLS = gws_pkg::MAX_COLS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // s_tdata: [7:0] ch
    input  logic [gws_pkg::S_TDATA_W-1:0]     s_tdata,
    // s_tuser: [0] first_of_grid
    input  logic [gws_pkg::S_TUSER_W-1:0]     s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // m_tdata: [2:0] matches_here, [26:3] total, [31:27] zero
    output logic [gws_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [gws_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [gws_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [gws_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int COL_W = $clog2(MAX_COLS);
    localparam int EW    = ($clog2(MAX_COLS + 3) > gws_pkg::ROW_W_W) ?
                           $clog2(MAX_COLS + 3) : gws_pkg::ROW_W_W;
    localparam logic [EW-1:0] MAX_EW   = EW'(MAX_COLS);
    localparam logic [1:0] ROWS_FULL   = 2'd3;
    localparam logic [1:0] PHASE_LAST  = 2'd2;

    logic [gws_pkg::ROW_W_W-1:0] row_width_reg;
    logic [COL_W-1:0]            col_reg,   col_next;
    logic [1:0]                  rows_reg,  rows_next;
    logic [1:0]                  phase_reg, phase_next;

    logic                        valid1_reg;
    gws_pkg::item_t              item1_reg, item0;
    logic                        out_valid_reg;
    logic [gws_pkg::MATCH_W-1:0] matches_reg;
    logic [gws_pkg::TOTAL_W-1:0] total_reg, total_next;

    logic                        s_acc, adv_out, xfer1, first, wrap, cfg_wr;
    logic [COL_W-1:0]            col0;
    logic [1:0]                  rows0, phase0;
    logic [EW-1:0]               rw_ext, w_eff, col_ext;
    logic [gws_pkg::MATCH_W-1:0] hit_count;
    logic [gws_pkg::TOTAL_W-1:0] total_base;
    logic [gws_pkg::TOTAL_W:0]   total_sum;
    gws_pkg::taps_t              taps;

    // ---- configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready &&
                    (paddr[gws_pkg::APB_ADDR_W-1:2] == gws_pkg::REG_ROW_WIDTH);
    assign prdata = (paddr[gws_pkg::APB_ADDR_W-1:2] == gws_pkg::REG_ROW_WIDTH) ?
                    gws_pkg::APB_DATA_W'(row_width_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_width_reg <= gws_pkg::ROW_WIDTH_RST;
        end else if (cfg_wr) begin
            row_width_reg <= pwdata[gws_pkg::ROW_W_W-1:0];
        end
    end

    // ---- handshake
    assign adv_out  = !out_valid_reg || m_tready;
    assign s_tready = !valid1_reg || adv_out;
    assign s_acc    = s_tvalid && s_tready;
    assign xfer1    = valid1_reg && adv_out;

    // ---- position of the incoming character
    always_comb begin
        first   = s_tuser[0];
        col0    = first ? '0 : col_reg;
        rows0   = first ? '0 : rows_reg;
        phase0  = first ? '0 : phase_reg;

        rw_ext  = EW'(row_width_reg);
        if (rw_ext == '0) begin
            w_eff = EW'(1);
        end else if (rw_ext > MAX_EW) begin
            w_eff = MAX_EW;
        end else begin
            w_eff = rw_ext;
        end

        col_ext        = EW'(col0);
        wrap           = (col_ext + EW'(1)) >= w_eff;
        item0.cur      = s_tdata[gws_pkg::CHAR_W-1:0];
        item0.first    = first;
        item0.col_ge3  = col_ext >= EW'(3);
        item0.full_rows = (rows0 == ROWS_FULL);
        item0.ahead_ok = (col_ext + EW'(3)) < w_eff;

        if (wrap) begin
            col_next   = '0;
            rows_next  = (rows0 == ROWS_FULL) ? rows0 : rows0 + 2'd1;
            phase_next = (phase0 == PHASE_LAST) ? '0 : phase0 + 2'd1;
        end else begin
            col_next   = col0 + COL_W'(1);
            rows_next  = rows0;
            phase_next = phase0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg   <= '0;
            rows_reg  <= '0;
            phase_reg <= '0;
        end else if (s_acc) begin
            col_reg   <= col_next;
            rows_reg  <= rows_next;
            phase_reg <= phase_next;
        end
    end

    // ---- row buffers, read in the accept cycle
    gws_line_buf #(
        .MAX_COLS (MAX_COLS)
    ) u_line_buf (
        .aclk  (aclk),
        .rd_en (s_acc),
        .phase (phase0),
        .col   (col0),
        .cur   (item0.cur),
        .taps  (taps)
    );

    // ---- compare stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid1_reg <= 1'b0;
        end else if (s_acc) begin
            valid1_reg <= 1'b1;
        end else if (xfer1) begin
            valid1_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_acc) begin
            item1_reg <= item0;
        end
    end

    gws_match u_match (
        .aclk      (aclk),
        .shift     (xfer1),
        .item      (item1_reg),
        .taps      (taps),
        .hit_count (hit_count)
    );

    // ---- running total and result register
    always_comb begin
        total_base = item1_reg.first ? '0 : total_reg;
        total_sum  = {1'b0, total_base} + (gws_pkg::TOTAL_W + 1)'(hit_count);
        total_next = total_sum[gws_pkg::TOTAL_W] ? gws_pkg::TOTAL_MAX
                                                 : total_sum[gws_pkg::TOTAL_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            total_reg     <= '0;
        end else if (xfer1) begin
            out_valid_reg <= 1'b1;
            total_reg     <= total_next;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (xfer1) begin
            matches_reg <= hit_count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{gws_pkg::M_PAD_W{1'b0}}, total_reg, matches_reg};

`ifndef SYNTHESIS
    // input stalls only when both stages are full and the result is held
    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (valid1_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a held result");

    // total never falls within a grid
    a_total_mono: assert property (@(posedge aclk) disable iff (!aresetn)
        (xfer1 && !item1_reg.first) |=> (total_reg >= $past(total_reg)))
        else $error("running total decreased without restart");

    // at most four windows end at one cell
    a_match_range: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (matches_reg <= 3'd4))
        else $error("match count out of range");

    // row phase moves only on a column wrap or restart
    a_phase_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_acc && !wrap && !first) |=> $stable(phase_reg))
        else $error("row phase moved inside a row");
`endif

endmodule
